### src/store_queue_burst_unit_defines.svh
// Assertion macros for the store queue burst unit modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef STORE_QUEUE_BURST_UNIT_DEFINES_SVH
`define STORE_QUEUE_BURST_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SQBU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define SQBU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/sqbu_pkg.sv
// Package of the store queue burst unit: widths, codes and the
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package sqbu_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned BeatW    = 3;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned MapIdxW  = 6;
  localparam int unsigned MapDepth = 64;
  localparam int unsigned MapW     = 12;
  localparam int unsigned AreaW    = 3;
  localparam int unsigned OffsW    = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  localparam logic [BeatW-1:0] LastBeat = 3'd7;

  localparam logic KindRead = 1'b0;
  localparam logic KindBeat = 1'b1;

  typedef enum logic [ModeW-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_MAP   = 2'd3
  } sqbu_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRANSLATE = 2'd0,
    CFG_AREA0     = 2'd1,
    CFG_AREA1     = 2'd2
  } sqbu_cfg_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } sqbu_state_e;

  typedef struct packed {
    logic             wr_word;
    logic             wr_map;
    logic             flush_start;
    logic             load_read;
    logic             load_beat;
    logic [BeatW-1:0] beat;
  } sqbu_cmd_t;

  typedef struct packed {
    logic out_valid;
  } sqbu_status_t;

endpackage

### src/store_queue_burst_unit.sv
// Top level of the store queue burst unit: joins the controller and the
// datapath. Depends on sqbu_pkg, sqbu_ctrl and sqbu_datapath.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o   mode, address, store_word, map_index,
//                                                 map_upper_bits
//   out      output     out_valid_o / out_ready_i result_kind, word_out, beat_address,
//                                                 last_beat
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Writes, map loads and reads may follow back to back while the output register has room.
// A flush first registers the map lookup, then sends one beat per cycle, while the
// output is not stalled, through the single output register, counted by the beat counter.
// Input is held off during a burst, and any stall on the output stretches it.
// Reset clears the queues, the map valid flags, the config registers and out_valid.
`timescale 1ns / 1ps

module store_queue_burst_unit
  import sqbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [WordW-1:0]    address_i,
  input  logic [WordW-1:0]    store_word_i,
  input  logic [MapIdxW-1:0]  map_index_i,
  input  logic [MapW-1:0]     map_upper_bits_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_kind_o,
  output logic [WordW-1:0]    word_out_o,
  output logic [WordW-1:0]    beat_address_o,
  output logic                last_beat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sqbu_cmd_t    cmd;
  sqbu_status_t status;

  sqbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sqbu_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .address_i        (address_i),
    .store_word_i     (store_word_i),
    .map_index_i      (map_index_i),
    .map_upper_bits_i (map_upper_bits_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .result_kind_o    (result_kind_o),
    .word_out_o       (word_out_o),
    .beat_address_o   (beat_address_o),
    .last_beat_o      (last_beat_o)
  );

endmodule

### src/sqbu_ctrl.sv
// Controller of the store queue burst unit: accepts items and sequences
// the eight beats of a flush. Depends on sqbu_pkg and store_queue_burst_unit_defines.svh.
`timescale 1ns / 1ps
`include "store_queue_burst_unit_defines.svh"

module sqbu_ctrl
  import sqbu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic             out_ready_i,
  input  sqbu_status_t     status_i,
  output sqbu_cmd_t        cmd_o
);

  sqbu_state_e      state_q, state_d;
  logic [BeatW-1:0] beat_q, beat_d;
  logic             out_free;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      beat_q  <= '0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
    end
  end

  always_comb begin
    out_free   = !status_i.out_valid || out_ready_i;
    state_d    = state_q;
    beat_d     = beat_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    cmd_o      = '0;
    cmd_o.beat = beat_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        accept     = in_valid_i && out_free;
        if (accept) begin
          case (sqbu_mode_e'(mode_i))
            MODE_WRITE: cmd_o.wr_word = 1'b1;
            MODE_READ:  cmd_o.load_read = 1'b1;
            MODE_FLUSH: begin
              cmd_o.flush_start = 1'b1;
              beat_d            = '0;
              state_d           = ST_BURST;
            end
            MODE_MAP:   cmd_o.wr_map = 1'b1;
            default:    cmd_o.wr_map = 1'b0;
          endcase
        end
      end
      ST_BURST: begin
        if (out_free) begin
          cmd_o.load_beat = 1'b1;
          if (beat_q == LastBeat) begin
            state_d = ST_IDLE;
          end else begin
            beat_d = beat_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `SQBU_ASSERT(a_flush_enters_burst, cmd_o.flush_start |=> (state_q == ST_BURST && beat_q == '0), "flush did not start a burst at beat zero")
  `SQBU_ASSERT(a_last_beat_ends, (cmd_o.load_beat && beat_q == LastBeat) |=> (state_q == ST_IDLE), "burst did not end after the last beat")
  `SQBU_ASSERT(a_load_needs_room, (cmd_o.load_beat || cmd_o.load_read) |-> (!status_i.out_valid || out_ready_i), "output register overwritten while full")

endmodule

### src/sqbu_datapath.sv
// Datapath of the store queue burst unit: queue words, translation map,
// configuration registers, address build and the output register.
// Depends on sqbu_pkg.
`timescale 1ns / 1ps

module sqbu_datapath
  import sqbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqbu_cmd_t           cmd_i,
  output sqbu_status_t        status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [WordW-1:0]    address_i,
  input  logic [WordW-1:0]    store_word_i,
  input  logic [MapIdxW-1:0]  map_index_i,
  input  logic [MapW-1:0]     map_upper_bits_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                result_kind_o,
  output logic [WordW-1:0]    word_out_o,
  output logic [WordW-1:0]    beat_address_o,
  output logic                last_beat_o
);

  logic [WordW-1:0]    queue_q [2**SlotW];
  logic [MapW-1:0]     map_mem [MapDepth];
  logic [MapDepth-1:0] map_vld_q;
  logic [MapW-1:0]     map_rd_q;
  logic                map_rd_vld_q;

  logic                trans_en_q;
  logic [AreaW-1:0]    area0_q, area1_q;
  logic                queue_sel_q;
  logic [OffsW-1:0]    offs_q;

  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  logic [WordW-1:0]    word_q, word_d;
  logic [WordW-1:0]    baddr_q, baddr_d;
  logic                last_q, last_d;

  logic [MapW-1:0]     upper;
  logic [AreaW-1:0]    area;
  logic [WordW-1:0]    base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2**SlotW; i++) begin
        queue_q[i] <= '0;
      end
    end else if (cmd_i.wr_word) begin
      queue_q[address_i[5:2]] <= store_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_map) begin
      map_mem[map_index_i] <= map_upper_bits_i;
    end
    if (cmd_i.flush_start) begin
      map_rd_q <= map_mem[address_i[25:20]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q    <= '0;
      map_rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_map) begin
        map_vld_q[map_index_i] <= 1'b1;
      end
      if (cmd_i.flush_start) begin
        map_rd_vld_q <= map_vld_q[address_i[25:20]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_en_q <= 1'b0;
      area0_q    <= '0;
      area1_q    <= '0;
    end else if (cfg_we_i) begin
      case (sqbu_cfg_e'(cfg_idx_i))
        CFG_TRANSLATE: trans_en_q <= cfg_data_i[0];
        CFG_AREA0:     area0_q    <= cfg_data_i[AreaW-1:0];
        CFG_AREA1:     area1_q    <= cfg_data_i[AreaW-1:0];
        default:       trans_en_q <= trans_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_start) begin
      queue_sel_q <= address_i[5];
      offs_q      <= address_i[25:5];
    end
  end

  always_comb begin
    upper = map_rd_vld_q ? map_rd_q : '0;
    area  = queue_sel_q ? area1_q : area0_q;
    if (trans_en_q) begin
      base = {upper, offs_q[14:0], 5'b0};
    end else begin
      base = {3'b0, area, offs_q, 5'b0};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    word_d      = word_q;
    baddr_d     = baddr_q;
    last_d      = last_q;
    if (cmd_i.load_read) begin
      out_valid_d = 1'b1;
      kind_d      = KindRead;
      word_d      = queue_q[address_i[5:2]];
      baddr_d     = '0;
      last_d      = 1'b1;
    end else if (cmd_i.load_beat) begin
      out_valid_d = 1'b1;
      kind_d      = KindBeat;
      word_d      = queue_q[{queue_sel_q, cmd_i.beat}];
      baddr_d     = {base[WordW-1:5], cmd_i.beat, 2'b0};
      last_d      = (cmd_i.beat == LastBeat);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    word_q  <= word_d;
    baddr_q <= baddr_d;
    last_q  <= last_d;
  end

  assign status_o.out_valid = out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign word_out_o         = word_q;
  assign beat_address_o     = baddr_q;
  assign last_beat_o        = last_q;

endmodule

### test/testbench.sv
// Self-checking testbench for store_queue_burst_unit: directed and random items with
// random idling on both channels, checked against a behavioral predictor in this file.
// Depends on sqbu_pkg and the store_queue_burst_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import sqbu_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned TailCycles   = 20;
  localparam int unsigned PhaseItems   = 40;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef enum logic [2:0] {
    PLAN_ITEM,
    PLAN_CFG,
    PLAN_DRAIN,
    PLAN_HOLD,
    PLAN_CALM
  } plan_e;

  typedef struct {
    plan_e                kind;
    sqbu_mode_e           mode;
    logic [WordW-1:0]     address;
    logic [WordW-1:0]     data;
    logic [MapIdxW-1:0]   map_index;
    logic [MapW-1:0]      map_bits;
    logic [CfgIdxW-1:0]   cfg_idx;
    logic [CfgDataW-1:0]  cfg_data;
  } plan_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic [WordW-1:0] address;
    logic             last;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode_i = '0;
  logic [WordW-1:0]    address_i = '0;
  logic [WordW-1:0]    store_word_i = '0;
  logic [MapIdxW-1:0]  map_index_i = '0;
  logic [MapW-1:0]     map_upper_bits_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                result_kind_o;
  logic [WordW-1:0]    word_out_o;
  logic [WordW-1:0]    beat_address_o;
  logic                last_beat_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  store_queue_burst_unit dut (.*);

  logic [WordW-1:0]   sq_words [2 ** SlotW];
  logic [MapW-1:0]    xlat_map [MapDepth];
  logic               xlat_on = 1'b0;
  logic [AreaW-1:0]   area [2];

  plan_t              plan [$];
  beat_t              expected_beats [$];
  logic [MapIdxW-1:0] loaded_map_idx [$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  logic        in_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet = 0;
  int unsigned tx_odds = 2;
  int unsigned rx_odds = 2;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void predict_item(input sqbu_mode_e mode, input logic [WordW-1:0] addr,
                                       input logic [WordW-1:0] data,
                                       input logic [MapIdxW-1:0] midx,
                                       input logic [MapW-1:0] mval);
    logic             q;
    logic [WordW-1:0] base;
    q = addr[5];
    case (mode)
      MODE_WRITE: begin
        sq_words[{q, addr[4:2]}] = data;
      end
      MODE_READ: begin
        expected_beats.push_back('{kind: KindRead, word: sq_words[{q, addr[4:2]}],
                                   address: '0, last: 1'b1});
      end
      MODE_FLUSH: begin
        if (xlat_on) begin
          base = {xlat_map[addr[25:20]], addr[19:5], 5'b0};
        end else begin
          base = {3'b000, area[q], addr[25:5], 5'b0};
        end
        for (int i = 0; i < (1 << BeatW); i++) begin
          expected_beats.push_back('{kind: KindBeat, word: sq_words[{q, i[BeatW-1:0]}],
                                     address: base + WordW'(4 * i),
                                     last: i[BeatW-1:0] == LastBeat});
        end
      end
      default: begin
        xlat_map[midx] = mval;
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result word", word_out_o, '0);
        end else begin
          want = expected_beats.pop_front();
          if (result_kind_o !== want.kind) begin
            report_mismatch("result_kind", WordW'(result_kind_o), WordW'(want.kind));
          end
          if (word_out_o !== want.word) begin
            report_mismatch("word_out", word_out_o, want.word);
          end
          if (beat_address_o !== want.address) begin
            report_mismatch("beat_address", beat_address_o, want.address);
          end
          if (last_beat_o !== want.last) begin
            report_mismatch("last_beat", WordW'(last_beat_o), WordW'(want.last));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRANSLATE: xlat_on = cfg_data_i[0];
          CFG_AREA0:     area[0] = cfg_data_i;
          CFG_AREA1:     area[1] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        predict_item(sqbu_mode_e'(mode_i), address_i, store_word_i, map_index_i,
                     map_upper_bits_i);
      end
    end
    in_taken = rst_ni && in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    logic valid_n;
    logic we_n;
    if (rst_ni) begin
      valid_n = in_valid_i && !in_taken;
      we_n = 1'b0;
      if (cycle_count % 128 == 0) begin
        tx_odds = $urandom_range(0, 2) * 2;
      end
      if (expected_beats.size() == 0 && !valid_n) begin
        quiet++;
      end else begin
        quiet = 0;
      end
      if (!valid_n && gap_left != 0) begin
        gap_left--;
      end else if (!valid_n && plan.size() != 0) begin
        case (plan[0].kind)
          PLAN_ITEM: begin
            mode_i <= plan[0].mode;
            address_i <= plan[0].address;
            store_word_i <= plan[0].data;
            map_index_i <= plan[0].map_index;
            map_upper_bits_i <= plan[0].map_bits;
            valid_n = 1'b1;
            gap_left = (!calm && $urandom_range(0, 7) < tx_odds) ? $urandom_range(1, 17) : 0;
            void'(plan.pop_front());
          end
          PLAN_CFG: begin
            if (quiet >= SettleCycles) begin
              we_n = 1'b1;
              cfg_idx_i <= plan[0].cfg_idx;
              cfg_data_i <= plan[0].cfg_data;
              void'(plan.pop_front());
            end
          end
          PLAN_DRAIN: begin
            if (quiet >= SettleCycles) begin
              void'(plan.pop_front());
            end
          end
          PLAN_HOLD: begin
            hold_asks <= hold_asks + 1;
            void'(plan.pop_front());
          end
          default: begin
            calm <= 1'b1;
            void'(plan.pop_front());
          end
        endcase
      end
      in_valid_i <= valid_n;
      cfg_we_i <= we_n;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cycle_count % 128 == 64) begin
        rx_odds = $urandom_range(0, 2) * 2;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served != hold_asks) begin
        holds_served++;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) < rx_odds) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void add_item(input sqbu_mode_e mode, input logic [WordW-1:0] addr,
                                   input logic [WordW-1:0] data,
                                   input logic [MapIdxW-1:0] midx,
                                   input logic [MapW-1:0] mval);
    plan.push_back('{PLAN_ITEM, mode, addr, data, midx, mval, '0, '0});
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] value);
    plan.push_back('{PLAN_CFG, MODE_WRITE, '0, '0, '0, '0, idx, value});
  endfunction

  function automatic void add_mark(input plan_e kind);
    plan.push_back('{kind, MODE_WRITE, '0, '0, '0, '0, '0, '0});
  endfunction

  function automatic void add_settings(input logic [CfgDataW-1:0] xlat,
                                       input logic [CfgDataW-1:0] area0,
                                       input logic [CfgDataW-1:0] area1);
    add_mark(PLAN_DRAIN);
    add_cfg(CFG_TRANSLATE, xlat);
    add_cfg(CFG_AREA0, area0);
    add_cfg(CFG_AREA1, area1);
  endfunction

  // A mix of single accesses, flushes, map loads and complete fill-then-flush sequences.
  function automatic void add_random_items(input int unsigned count);
    int unsigned      n;
    int unsigned      pick;
    logic             q;
    logic [WordW-1:0] a;
    logic [MapIdxW-1:0] midx;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 11);
      a = $urandom;
      if (pick == 0) begin
        q = 1'($urandom_range(0, 1));
        for (int w = 0; w < (1 << BeatW); w++) begin
          a = $urandom;
          a[5] = q;
          a[4:2] = w[2:0];
          add_item(MODE_WRITE, a, $urandom, MapIdxW'($urandom), MapW'($urandom));
        end
        a = $urandom;
        a[5] = q;
        add_item(MODE_FLUSH, a, $urandom, MapIdxW'($urandom), MapW'($urandom));
        n += 9;
      end else if (pick <= 4) begin
        add_item(MODE_WRITE, a, $urandom, MapIdxW'($urandom), MapW'($urandom));
        n++;
      end else if (pick <= 6) begin
        add_item(MODE_READ, a, $urandom, MapIdxW'($urandom), MapW'($urandom));
        n++;
      end else if (pick <= 9) begin
        if (loaded_map_idx.size() != 0 && $urandom_range(0, 1) == 1) begin
          a[25:20] = loaded_map_idx[$urandom_range(0, loaded_map_idx.size() - 1)];
        end
        add_item(MODE_FLUSH, a, $urandom, MapIdxW'($urandom), MapW'($urandom));
        n++;
      end else begin
        midx = MapIdxW'($urandom);
        loaded_map_idx.push_back(midx);
        add_item(MODE_MAP, a, $urandom, midx, MapW'($urandom));
        n++;
      end
    end
  endfunction

  initial begin
    for (int i = 0; i < 2 ** SlotW; i++) sq_words[i] = '0;
    for (int i = 0; i < MapDepth; i++) xlat_map[i] = '0;
    area[0] = '0;
    area[1] = '0;

    add_item(MODE_READ,  32'h0000_0000, 32'h0, 6'h00, 12'h000);
    add_item(MODE_READ,  32'h0000_003C, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'h0000_0000, 32'h0, 6'h00, 12'h000);
    add_item(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 12'hFFF);
    add_item(MODE_WRITE, 32'h0000_0003, 32'h8000_0001, 6'h00, 12'h000);
    add_item(MODE_WRITE, 32'hFFFF_FFDC, 32'hA5A5_A5A5, 6'h2A, 12'h555);
    add_item(MODE_WRITE, 32'h0000_0020, 32'h0000_0000, 6'h15, 12'hAAA);
    add_item(MODE_READ,  32'hFFFF_FFFF, 32'h0, 6'h00, 12'h000);
    add_item(MODE_READ,  32'h0000_0003, 32'h0, 6'h00, 12'h000);
    add_item(MODE_MAP,   32'h0000_0000, 32'h0, 6'h3F, 12'hFFF);
    add_item(MODE_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h00, 12'hABC);
    add_item(MODE_MAP,   32'h0000_0004, 32'h1234_5678, 6'h15, 12'h000);
    add_item(MODE_READ,  32'hFFFF_FFDC, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'hFFFF_FFFF, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'hFFFF_FFDF, 32'h0, 6'h00, 12'h000);

    add_settings(3'b111, 3'd7, 3'd5);
    add_cfg(CfgIdxUnused, 3'd7);
    add_item(MODE_FLUSH, 32'hFFFF_FFFF, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'h0000_0000, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'h0150_0020, 32'h0, 6'h00, 12'h000);
    add_item(MODE_MAP,   32'h0000_0000, 32'h0, 6'h00, 12'h000);
    add_item(MODE_FLUSH, 32'h000F_FFFC, 32'h0, 6'h00, 12'h000);

    add_settings(3'b110, 3'd7, 3'd7);
    add_random_items(PhaseItems);
    add_settings(3'b001, 3'd0, 3'd0);
    add_mark(PLAN_HOLD);
    add_random_items(PhaseItems);
    add_settings(3'b000, CfgDataW'($urandom), CfgDataW'($urandom));
    add_random_items(PhaseItems / 2);
    add_mark(PLAN_DRAIN);
    add_random_items(PhaseItems / 2);
    add_settings(3'b011, 3'd3, 3'd4);
    add_random_items(PhaseItems);
    add_mark(PLAN_CALM);
    add_settings(3'b100, 3'd2, 3'd6);
    add_random_items(PhaseItems);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(posedge clk_i);
    while (plan.size() != 0 || in_valid_i || expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### store_queue_burst_unit.f
+incdir+src
src/sqbu_pkg.sv
src/sqbu_ctrl.sv
src/sqbu_datapath.sv
src/store_queue_burst_unit.sv
test/testbench.sv
